FILE: src/rrsa_pkg.sv
package rrsa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int WW            = 32;
    localparam int OW            = 5;
    localparam int SLOT_W        = 10;
    localparam int ACT_W         = 11;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [ACT_W-1:0] ACT_RESET  = 11'd1024;
    localparam logic             REQ_ALLOC  = 1'b0;
    localparam logic             REQ_FREE   = 1'b1;
    localparam logic             REG_ACTIVE = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] granted_slot;
    } t_out_item;

    typedef struct packed {
        logic          hit;
        logic [OW-1:0] off;
    } t_find;

endpackage

FILE: src/rrsa_mem.sv
module rrsa_mem import rrsa_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [WW-1:0] o_rdata
);

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rrsa_find.sv
module rrsa_find import rrsa_pkg::*; #(
    parameter int AW = 5,
    parameter int SW = AW + OW,
    parameter int CW = SW + 1
) (
    input  logic [WW-1:0] i_data,
    input  logic [AW-1:0] i_word,
    input  logic [SW-1:0] i_start,
    input  logic [CW-1:0] i_lim,
    input  logic          i_wrap,
    output t_find         o_find
);

    logic [WW-1:0] cand;

    always_comb begin
        logic [SW-1:0] slot;
        for (int b = 0; b < WW; b++) begin
            slot    = {i_word, OW'(b)};
            cand[b] = !i_data[b] && (CW'(slot) < i_lim) && (i_wrap || (slot >= i_start));
        end
    end

    always_comb begin
        o_find = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_find.hit = 1'b1;
                o_find.off = OW'(b);
            end
        end
    end

endmodule

FILE: src/round_robin_slot_allocator.sv
// Release: the word is read on accept; ST_REL clears an in-range bit, sets the result.
// Allocate: the pointer's word is read on accept; ST_SCAN reads one 32-slot word of
//   the busy-flag memory at a time and stops in the first word if a free slot lies
//   at or after the pointer there. One item in flight; the next is taken while the
//   result waits in the output register.
// Synchronous active-low reset; then a clearing pass zeroes the flag memory while the
//   input stalls. Config writes are taken in every state, but not during reset.
module round_robin_slot_allocator import rrsa_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int NW = (MAX_SLOTS + WW - 1) / WW;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int SW = AW + OW;
    localparam int CW = SW + 1;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_REL  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [ACT_W-1:0] r_active;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [SW-1:0]    r_p, n_p;
    logic [AW-1:0]    r_word, n_word;
    logic             r_wrap, n_wrap;
    logic [OW-1:0]    r_off, n_off;
    logic             r_idx_ok, n_idx_ok;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [ACT_W-1:0] eff;
    logic [CW-1:0]    cnt;
    logic [SW-1:0]    p_start;
    logic [SW-1:0]    idx_s;
    logic             idx_ok;
    logic             accept;
    logic             ofree;
    logic [CW-1:0]    lim;
    logic [SW-1:0]    slot_hit;
    logic [CW-1:0]    nxt_base;
    logic             fail;
    t_find            fnd;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [WW-1:0]    mem_wdata, mem_rdata;

    assign eff     = (r_active == '0) ? ACT_W'(1) : r_active;
    assign cnt     = (32'(eff) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(eff);
    assign p_start = (CW'(r_ptr) < cnt) ? r_ptr : '0;
    assign idx_s   = SW'(i_in_data.slot_index);
    assign idx_ok  = 32'(i_in_data.slot_index) < 32'(cnt);
    assign accept  = i_in_valid && !o_in_stall;
    assign ofree   = !r_out_valid || !i_out_stall;

    assign lim      = r_wrap ? CW'(r_p) : cnt;
    assign slot_hit = {r_word, fnd.off};
    assign nxt_base = CW'({r_word, OW'(0)}) + CW'(WW);
    assign fail     = r_wrap ? (nxt_base >= CW'(r_p)) : ((nxt_base >= cnt) && (r_p == '0));

    rrsa_find #(.AW(AW), .SW(SW), .CW(CW)) u_find (
        .i_data  (mem_rdata),
        .i_word  (r_word),
        .i_start (r_p),
        .i_lim   (lim),
        .i_wrap  (r_wrap),
        .o_find  (fnd)
    );

    rrsa_mem #(.DEPTH(NW), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ptr       = r_ptr;
        n_p         = r_p;
        n_word      = r_word;
        n_wrap      = r_wrap;
        n_off       = r_off;
        n_idx_ok    = r_idx_ok;
        n_out_valid = (r_out_valid && i_out_stall);
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_word;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_word;

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(NW - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    mem_re   = 1'b1;
                    n_p      = p_start;
                    n_wrap   = 1'b0;
                    n_off    = idx_s[OW-1:0];
                    n_idx_ok = idx_ok;
                    if (i_in_data.req_type == REQ_ALLOC) begin
                        n_word  = p_start[SW-1:OW];
                        n_state = ST_SCAN;
                    end else begin
                        n_word  = idx_s[SW-1:OW];
                        n_state = ST_REL;
                    end
                    mem_raddr = n_word;
                end
            end
            ST_SCAN: begin
                if (fnd.hit) begin
                    if (ofree) begin
                        mem_we      = 1'b1;
                        mem_wdata   = mem_rdata | (WW'(1) << fnd.off);
                        n_out_valid = 1'b1;
                        n_out       = '{granted: 1'b1, granted_slot: SLOT_W'(slot_hit)};
                        n_ptr       = (CW'(slot_hit) + CW'(1) == cnt) ? '0
                                                                      : slot_hit + SW'(1);
                        n_state     = ST_IDLE;
                    end
                end else if (fail) begin
                    if (ofree) begin
                        n_out_valid = 1'b1;
                        n_out       = '{granted: 1'b0, granted_slot: '0};
                        n_ptr       = (r_p == '0) ? SW'(cnt - CW'(1)) : r_p - SW'(1);
                        n_state     = ST_IDLE;
                    end
                end else begin
                    mem_re = 1'b1;
                    if (!r_wrap && (nxt_base >= cnt)) begin
                        n_word = '0;
                        n_wrap = 1'b1;
                    end else begin
                        n_word = r_word + AW'(1);
                    end
                    mem_raddr = n_word;
                end
            end
            ST_REL: begin
                if (ofree) begin
                    mem_we      = r_idx_ok;
                    mem_wdata   = mem_rdata & ~(WW'(1) << r_off);
                    n_out_valid = 1'b1;
                    n_out       = '{granted: r_idx_ok, granted_slot: '0};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_active    <= ACT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ACTIVE)) begin
                r_active <= pwdata[ACT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_word   <= n_word;
        r_wrap   <= n_wrap;
        r_off    <= n_off;
        r_idx_ok <= n_idx_ok;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[PADDR_W-1] == REG_ACTIVE) ? PDATA_W'(r_active) : '0;

endmodule

FILE: src/rrsa_chk.sv
module rrsa_chk import rrsa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.granted |-> o_out_data.granted_slot == '0)
        else $error("denied result carries a slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted in back-to-back cycles");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input open during clearing pass");

endmodule

bind round_robin_slot_allocator rrsa_chk u_rrsa_chk (.*);

FILE: tb/sv/round_robin_slot_allocator_checker.sv
module round_robin_slot_allocator_checker import rrsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  t_out_item          i_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_denied,
    output int                 o_out_of_range
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUE_DEPTH = 16;

    bit               slot_taken [MAX_SLOTS_DEF];
    logic [SLOT_W-1:0] scan_ptr;
    logic [ACT_W-1:0]  active_cnt;
    t_out_item         grants_due [DUE_DEPTH];
    int                due_head = 0;
    int                due_tail = 0;

    int fails     = 0;
    int predicted = 0;
    int checked   = 0;
    int denied    = 0;
    int rejected  = 0;

    assign o_failures     = fails;
    assign o_pending      = predicted - checked;
    assign o_denied       = denied;
    assign o_out_of_range = rejected;

    function automatic int unsigned pool_size();
        int unsigned n;
        n = active_cnt;
        if (n == 0) n = 1;
        if (n > MAX_SLOTS_DEF) n = MAX_SLOTS_DEF;
        return n;
    endfunction

    function automatic int unsigned next_slot(int unsigned p, int unsigned n);
        return (p + 1 < n) ? p + 1 : 0;
    endfunction

    function automatic t_out_item serve_request(t_in_item rq);
        int unsigned n;
        int unsigned p;
        int unsigned k;
        bit          found;
        t_out_item   r;
        n = pool_size();
        r = '0;
        if (rq.req_type == REQ_ALLOC) begin
            p = (scan_ptr < n) ? scan_ptr : 0;
            found = 1'b0;
            for (k = 0; k < n && !found; k++) begin
                if (!slot_taken[p]) begin
                    slot_taken[p]  = 1'b1;
                    r.granted      = 1'b1;
                    r.granted_slot = SLOT_W'(p);
                    found          = 1'b1;
                    scan_ptr       = SLOT_W'(next_slot(p, n));
                end else if (k + 1 < n) begin
                    p = next_slot(p, n);
                end
            end
            if (!found) scan_ptr = SLOT_W'(p);
        end else if (rq.slot_index < n) begin
            slot_taken[rq.slot_index] = 1'b0;
            r.granted = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            scan_ptr   = '0;
            active_cnt = ACT_RESET;
        end else begin
            if (psel && penable && pready && paddr == PADDR_W'(4 * REG_ACTIVE)) begin
                if (pwrite) begin
                    active_cnt = pwdata[ACT_W-1:0];
                end else if (prdata !== PDATA_W'(active_cnt)) begin
                    fails++;
                    $display("%0t active_slots read: expected %0d actual %0d",
                             $time, active_cnt, prdata);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (due_tail == due_head) begin
                    fails++;
                    $display("%0t unexpected item: expected none actual granted=%0d slot=%0d",
                             $time, got.granted, got.granted_slot);
                end else begin
                    want = grants_due[due_head % DUE_DEPTH];
                    due_head++;
                    if (got.granted !== want.granted) begin
                        fails++;
                        $display("%0t granted: expected %0d actual %0d",
                                 $time, want.granted, got.granted);
                    end
                    if (got.granted_slot !== want.granted_slot) begin
                        fails++;
                        $display("%0t granted_slot: expected %0d actual %0d",
                                 $time, want.granted_slot, got.granted_slot);
                    end
                end
                checked <= checked + 1;
            end
            if (i_in_valid && !i_in_stall) begin
                want = serve_request(i_in_data);
                grants_due[due_tail % DUE_DEPTH] = want;
                due_tail++;
                predicted <= predicted + 1;
                if (!want.granted && i_in_data.req_type == REQ_ALLOC) denied <= denied + 1;
                if (!want.granted && i_in_data.req_type == REQ_FREE) rejected <= rejected + 1;
            end
        end
    end

endmodule

FILE: tb/sv/round_robin_slot_allocator_test.sv
module round_robin_slot_allocator_test import rrsa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT  = 10;
    localparam int REG_SPARE = 1;
    localparam int PER_PHASE = 110;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = PADDR_W'(4 * REG_ACTIVE);
    localparam logic [PADDR_W-1:0] ADDR_SPARE  = PADDR_W'(4 * REG_SPARE);

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic               i_out_stall = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int failures;
    int pending;
    int denied;
    int out_of_range;

    bit calm     = 1'b0;
    int sent     = 0;
    int settings = 1;

    round_robin_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    round_robin_slot_allocator_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .i_in_stall     (o_in_stall),
        .i_out_valid    (o_out_valid),
        .i_out_data     (o_out_data),
        .i_out_stall    (i_out_stall),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_denied       (denied),
        .o_out_of_range (out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** round_robin_slot_allocator: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic push_item(input logic req, input logic [SLOT_W-1:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_in_item'{req_type: req, slot_index: idx};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits are junk on purpose, only the low ACT_W bits are kept
    task automatic set_active(input int unsigned count);
        drain();
        apb_xfer(1'b1, ADDR_ACTIVE, ($urandom & ~PDATA_W'(11'h7FF)) | PDATA_W'(count));
        apb_xfer(1'b0, ADDR_ACTIVE, '0);
        settings++;
    endtask

    initial begin
        int unsigned phase_counts [8];
        int unsigned span;
        int unsigned alloc_pct;
        logic [SLOT_W-1:0] idx;
        phase_counts = '{1024, 2, 5, 32, 33, 64, 100, 1};
        phase_counts[7] = $urandom_range(1, 2047);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_xfer(1'b0, ADDR_ACTIVE, '0);

        // reset pool of 1024
        push_item(REQ_ALLOC, 10'h3FF);
        push_item(REQ_ALLOC, 10'h000);
        push_item(REQ_FREE, 10'h3FF);
        push_item(REQ_FREE, 10'h000);
        push_item(REQ_ALLOC, 10'h155);
        // single slot, pointer left beyond the pool
        set_active(1);
        push_item(REQ_ALLOC, 10'h2AA);
        push_item(REQ_ALLOC, 10'h000);
        push_item(REQ_FREE, 10'h001);
        push_item(REQ_FREE, 10'h000);
        push_item(REQ_ALLOC, 10'h000);
        // zero count acts as one
        set_active(0);
        push_item(REQ_ALLOC, 10'h000);
        push_item(REQ_FREE, 10'h3FF);
        push_item(REQ_FREE, 10'h000);
        // count above the maximum saturates
        set_active(2047);
        push_item(REQ_ALLOC, 10'h000);
        push_item(REQ_FREE, 10'h3FF);
        push_item(REQ_FREE, 10'h200);
        push_item(REQ_FREE, 10'h155);
        push_item(REQ_FREE, 10'h2AA);
        drain();
        apb_xfer(1'b1, ADDR_SPARE, 32'd5);
        push_item(REQ_ALLOC, 10'h000);
        set_active(3);
        repeat (4) push_item(REQ_ALLOC, SLOT_W'($urandom));

        foreach (phase_counts[ph]) begin
            set_active(phase_counts[ph]);
            calm = (ph == 2);
            span = (phase_counts[ph] > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : phase_counts[ph];
            alloc_pct = $urandom_range(35, 70);
            repeat (PER_PHASE) begin
                if ($urandom_range(99) < 80) idx = SLOT_W'($urandom_range(span - 1, 0));
                else idx = SLOT_W'($urandom);
                push_item(($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_FREE, idx);
            end
        end
        calm = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests over %0d pool sizes: %0d refused allocations,",
                 sent, settings, denied);
        $display("%0d out-of-range releases", out_of_range);
        if (failures == 0 && pending == 0) begin
            $display("** round_robin_slot_allocator: PASSED **");
        end else begin
            $display("** round_robin_slot_allocator: FAILED **");
        end
        $finish;
    end

endmodule
